// File: rtl/sss_pkg.sv
// Shared types and constants for the sparse segment row sum block.
// Item and result structs, mode and status codes, configuration register map.
// No dependencies.
`default_nettype none

package sss_pkg;

  localparam int WORD_W = 32;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;

  localparam int ROW_COUNT_W    = 9;
  localparam int ROW_WIDTH_W    = 5;
  localparam int NUM_SEGMENTS_W = 9;

  localparam logic [ROW_COUNT_W-1:0]    ROW_COUNT_RST    = 9'd256;
  localparam logic [ROW_WIDTH_W-1:0]    ROW_WIDTH_RST    = 5'd16;
  localparam logic [NUM_SEGMENTS_W-1:0] NUM_SEGMENTS_RST = 9'd256;

  localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_WIDTH    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_SEGMENTS = 2'd2;

  typedef enum logic [1:0] {
    MODE_LOAD  = 2'd0,
    MODE_START = 2'd1,
    MODE_PAIR  = 2'd2,
    MODE_READ  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_UNSORTED  = 2'd1,
    ST_SEG_RANGE = 2'd2,
    ST_IDX_RANGE = 2'd3
  } status_t;

  typedef struct packed {
    mode_t                    mode;
    logic signed [WORD_W-1:0] row_index;
    logic signed [WORD_W-1:0] segment_id;
    logic [3:0]               column;
    logic signed [WORD_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    status_t                  status;
    logic signed [WORD_W-1:0] read_data;
    logic                     error_seen;
  } out_item_t;

endpackage

`default_nettype wire

// File: rtl/sparse_segment_row_sum.sv
// Sparse segment row sum: source row table, per-segment output rows, one shared adder.
// Depends on sss_pkg for item types, mode and status codes, register map.
//
// channel  | ports                          | transfer when
// ---------+--------------------------------+--------------------------------
// input    | in_valid, in_stall, in_data    | in_valid && !in_stall
// result   | out_valid, out_stall, out_data | out_valid && !out_stall
// config   | cfg_wr_en, cfg_index, cfg_wr_data | cfg_wr_en
//
// Pair: one read-add-write per column through the shared adder on the sum memory port,
// in steps check, add, finish. Load and read: check, then a load or read-request step,
// then finish. Start: a clearing pass over the sum memory, one entry a cycle, then finish.
// After reset the same clearing pass runs with in_stall high.
// One item at a time; a finished result waits in the output register while the next
// item is taken, and the block holds in its final step while the previous result is still stalled.
`default_nettype none

module sparse_segment_row_sum
  import sss_pkg::*;
#(
  parameter int MAX_ROWS = 256,
  parameter int MAX_COLS = 16,
  parameter int MAX_SEGS = 256
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wr_data
);

  localparam int SRC_DEPTH = MAX_ROWS * MAX_COLS;
  localparam int SUM_DEPTH = MAX_SEGS * MAX_COLS;
  localparam int SRC_AW = (SRC_DEPTH > 1) ? $clog2(SRC_DEPTH) : 1;
  localparam int SUM_AW = (SUM_DEPTH > 1) ? $clog2(SUM_DEPTH) : 1;
  localparam int ROW_IW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int SEG_IW = (MAX_SEGS > 1) ? $clog2(MAX_SEGS) : 1;
  localparam int ROW_CW = $clog2(MAX_ROWS + 1);
  localparam int COL_CW = $clog2(MAX_COLS + 1);
  localparam int SEG_CW = $clog2(MAX_SEGS + 1);

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_CHECK = 7'b0000100,
    S_LOAD  = 7'b0001000,
    S_ADD   = 7'b0010000,
    S_RDREQ = 7'b0100000,
    S_FIN   = 7'b1000000
  } state_t;

  state_t                      state_r, state_nxt;
  logic [ROW_COUNT_W-1:0]      row_count_r;
  logic [ROW_WIDTH_W-1:0]      row_width_r;
  logic [NUM_SEGMENTS_W-1:0]   num_segments_r;
  in_item_t                    item_r, item_nxt;
  status_t                     status_r, status_nxt;
  logic                        err_r, err_nxt;
  logic                        have_seg_r, have_seg_nxt;
  logic [SEG_IW-1:0]           last_seg_r, last_seg_nxt;
  logic [SRC_AW-1:0]           src_base_r, src_base_nxt;
  logic [SUM_AW-1:0]           dst_base_r, dst_base_nxt;
  logic [COL_CW-1:0]           iss_cnt_r, iss_cnt_nxt;
  logic                        rd_v_r, rd_v_nxt;
  logic [SUM_AW-1:0]           wr_addr_r, wr_addr_nxt;
  logic [SUM_AW-1:0]           clr_cnt_r, clr_cnt_nxt;
  logic                        clr_start_r, clr_start_nxt;
  logic                        out_valid_r, out_valid_nxt;
  out_item_t                   out_r, out_nxt;

  logic [ROW_CW-1:0]           rows_eff;
  logic [COL_CW-1:0]           cols_eff;
  logic [SEG_CW-1:0]           segs_eff;
  logic                        row_ok, seg_ok, col_ok, unsorted, issue;
  logic [ROW_IW-1:0]           row_idx;
  logic [SEG_IW-1:0]           seg_idx;

  logic [WORD_W-1:0]           src_mem [SRC_DEPTH];
  logic [WORD_W-1:0]           sum_mem [SUM_DEPTH];
  logic [WORD_W-1:0]           src_q, sum_q;
  logic                        src_we, src_re, sum_we, sum_re;
  logic [SRC_AW-1:0]           src_wa, src_ra;
  logic [SUM_AW-1:0]           sum_wa, sum_ra;
  logic [WORD_W-1:0]           sum_wd;

  always_comb begin
    if (row_count_r == '0) begin
      rows_eff = ROW_CW'(1);
    end else if (32'(row_count_r) > 32'(MAX_ROWS)) begin
      rows_eff = ROW_CW'(MAX_ROWS);
    end else begin
      rows_eff = ROW_CW'(row_count_r);
    end
    if (row_width_r == '0) begin
      cols_eff = COL_CW'(1);
    end else if (32'(row_width_r) > 32'(MAX_COLS)) begin
      cols_eff = COL_CW'(MAX_COLS);
    end else begin
      cols_eff = COL_CW'(row_width_r);
    end
    if (num_segments_r == '0) begin
      segs_eff = SEG_CW'(1);
    end else if (32'(num_segments_r) > 32'(MAX_SEGS)) begin
      segs_eff = SEG_CW'(MAX_SEGS);
    end else begin
      segs_eff = SEG_CW'(num_segments_r);
    end
  end

  assign row_ok   = !item_r.row_index[WORD_W-1] &&
                    (item_r.row_index[WORD_W-1:0] < 32'(rows_eff));
  assign seg_ok   = !item_r.segment_id[WORD_W-1] &&
                    (item_r.segment_id[WORD_W-1:0] < 32'(segs_eff));
  assign col_ok   = 32'(item_r.column) < 32'(cols_eff);
  assign unsorted = have_seg_r && ($signed(item_r.segment_id) < $signed(32'(last_seg_r)));
  assign row_idx  = item_r.row_index[ROW_IW-1:0];
  assign seg_idx  = item_r.segment_id[SEG_IW-1:0];
  assign issue    = iss_cnt_r != cols_eff;

  always_comb begin
    case (item_r.mode)
      MODE_LOAD:  status_nxt = (!row_ok || !col_ok) ? ST_IDX_RANGE : ST_OK;
      MODE_START: status_nxt = ST_OK;
      MODE_PAIR: begin
        if (unsorted) status_nxt = ST_UNSORTED;
        else if (!seg_ok) status_nxt = ST_SEG_RANGE;
        else if (!row_ok) status_nxt = ST_IDX_RANGE;
        else status_nxt = ST_OK;
      end
      MODE_READ: begin
        if (!seg_ok) status_nxt = ST_SEG_RANGE;
        else if (!col_ok) status_nxt = ST_IDX_RANGE;
        else status_nxt = ST_OK;
      end
      default: status_nxt = ST_OK;
    endcase
  end

  assign src_base_nxt = SRC_AW'(row_idx) * SRC_AW'(MAX_COLS);
  assign dst_base_nxt = SUM_AW'(seg_idx) * SUM_AW'(MAX_COLS);

  // memory ports
  assign src_we = (state_r == S_LOAD) && (status_r == ST_OK);
  assign src_wa = src_base_r + SRC_AW'(item_r.column);
  assign src_re = (state_r == S_ADD) && issue;
  assign src_ra = src_base_r + SRC_AW'(iss_cnt_r);
  assign sum_re = ((state_r == S_ADD) && issue) || (state_r == S_RDREQ);
  assign sum_ra = (state_r == S_RDREQ) ? dst_base_r + SUM_AW'(item_r.column)
                                       : dst_base_r + SUM_AW'(iss_cnt_r);
  assign sum_we = (state_r == S_CLEAR) || ((state_r == S_ADD) && rd_v_r);
  assign sum_wa = (state_r == S_CLEAR) ? clr_cnt_r : wr_addr_r;
  assign sum_wd = (state_r == S_CLEAR) ? '0 : sum_q + src_q;

  always_ff @(posedge clk) begin
    if (src_we) src_mem[src_wa] <= item_r.value;
    if (src_re) src_q <= src_mem[src_ra];
  end

  always_ff @(posedge clk) begin
    if (sum_we) sum_mem[sum_wa] <= sum_wd;
    if (sum_re) sum_q <= sum_mem[sum_ra];
  end

  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    err_nxt       = err_r;
    have_seg_nxt  = have_seg_r;
    last_seg_nxt  = last_seg_r;
    iss_cnt_nxt   = iss_cnt_r;
    rd_v_nxt      = 1'b0;
    wr_addr_nxt   = wr_addr_r;
    clr_cnt_nxt   = clr_cnt_r;
    clr_start_nxt = clr_start_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_nxt       = out_r;
    case (state_r)
      S_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + SUM_AW'(1);
        if (clr_cnt_r == SUM_AW'(SUM_DEPTH - 1)) begin
          clr_cnt_nxt = '0;
          state_nxt   = clr_start_r ? S_FIN : S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          item_nxt  = in_data;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        iss_cnt_nxt = '0;
        case (item_r.mode)
          MODE_LOAD: begin
            if (status_nxt != ST_OK) err_nxt = 1'b1;
            state_nxt = S_LOAD;
          end
          MODE_START: begin
            err_nxt       = 1'b0;
            have_seg_nxt  = 1'b0;
            last_seg_nxt  = '0;
            clr_start_nxt = 1'b1;
            clr_cnt_nxt   = '0;
            state_nxt     = S_CLEAR;
          end
          MODE_PAIR: begin
            if (status_nxt != ST_OK) begin
              err_nxt   = 1'b1;
              state_nxt = S_FIN;
            end else begin
              have_seg_nxt = 1'b1;
              last_seg_nxt = seg_idx;
              state_nxt    = S_ADD;
            end
          end
          MODE_READ: state_nxt = (status_nxt == ST_OK) ? S_RDREQ : S_FIN;
          default:   state_nxt = S_FIN;
        endcase
      end
      S_LOAD: state_nxt = S_FIN;
      S_ADD: begin
        if (issue) begin
          iss_cnt_nxt = iss_cnt_r + COL_CW'(1);
          rd_v_nxt    = 1'b1;
          wr_addr_nxt = sum_ra;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_RDREQ: state_nxt = S_FIN;
      S_FIN: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt      = 1'b1;
          out_nxt.status     = status_r;
          out_nxt.read_data  = ((item_r.mode == MODE_READ) && (status_r == ST_OK)) ?
                               sum_q : '0;
          out_nxt.error_seen = err_r;
          clr_start_nxt      = 1'b0;
          state_nxt          = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_CLEAR;
      row_count_r    <= ROW_COUNT_RST;
      row_width_r    <= ROW_WIDTH_RST;
      num_segments_r <= NUM_SEGMENTS_RST;
      err_r          <= 1'b0;
      have_seg_r     <= 1'b0;
      last_seg_r     <= '0;
      rd_v_r         <= 1'b0;
      clr_cnt_r      <= '0;
      clr_start_r    <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      err_r       <= err_nxt;
      have_seg_r  <= have_seg_nxt;
      last_seg_r  <= last_seg_nxt;
      rd_v_r      <= rd_v_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      clr_start_r <= clr_start_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_ROW_COUNT:    row_count_r    <= cfg_wr_data[ROW_COUNT_W-1:0];
          CFG_ROW_WIDTH:    row_width_r    <= cfg_wr_data[ROW_WIDTH_W-1:0];
          CFG_NUM_SEGMENTS: num_segments_r <= cfg_wr_data[NUM_SEGMENTS_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    item_r    <= item_nxt;
    out_r     <= out_nxt;
    iss_cnt_r <= iss_cnt_nxt;
    wr_addr_r <= wr_addr_nxt;
    if (state_r == S_CHECK) begin
      status_r   <= status_nxt;
      src_base_r <= src_base_nxt;
      dst_base_r <= dst_base_nxt;
    end
  end

  assign in_stall  = state_r != S_IDLE;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

// File: rtl/sss_checker.sv
// Port-level checks for sparse_segment_row_sum, attached by bind.
// Depends on sss_pkg for item types and status codes.
`default_nettype none

module sss_checker
  import sss_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_valid,
  input wire logic      in_stall,
  input wire logic      out_valid,
  input wire logic      out_stall,
  input wire out_item_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while previous item still in work");

  a_data_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.read_data != '0) |-> out_data.status == ST_OK)
    else $error("nonzero read data with error status");

  a_unsorted_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == ST_UNSORTED) |-> out_data.error_seen)
    else $error("unsorted pair without error mark");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind sparse_segment_row_sum sss_checker u_sss_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire

// File: test/tb_top.sv
`timescale 1ns / 100ps
// Self-checking bench for sparse_segment_row_sum: source loads, starts, row adds and reads.
// A predictor of the row and sum tables checks every result transfer in order.
// Depends on sss_pkg and the RTL of sparse_segment_row_sum.

module tb_top;
  import sss_pkg::*;

  localparam int ROWS_MAX = 256;
  localparam int COLS_MAX = 16;
  localparam int SEGS_MAX = 256;
  localparam int HOLD_AT = 150;
  localparam int HOLD_CYCLES = 400;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wr_data = '0;

  in_item_t pending_items[$];
  out_item_t predicted_results[$];

  logic [ROW_COUNT_W-1:0] cfg_rows = ROW_COUNT_RST;
  logic [ROW_WIDTH_W-1:0] cfg_width = ROW_WIDTH_RST;
  logic [NUM_SEGMENTS_W-1:0] cfg_segs = NUM_SEGMENTS_RST;

  logic [WORD_W-1:0] src_mem[ROWS_MAX*COLS_MAX];
  logic [WORD_W-1:0] sum_mem[SEGS_MAX*COLS_MAX];
  int last_seg = 0;
  bit have_seg = 1'b0;
  bit err_sticky = 1'b0;
  bit loaded[ROWS_MAX*COLS_MAX];

  int unsigned items_queued = 0;
  int unsigned results_seen = 0;
  int unsigned fail_count = 0;
  int unsigned phase_items = 0;
  int gap_left = 0;
  int stall_left = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  bit quiet = 1'b0;
  int unsigned quiet_cnt = 0;
  out_item_t want;

  sparse_segment_row_sum i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wr_data(cfg_wr_data)
  );

  always #5 clk = ~clk;

  function automatic int clamp_cfg(int unsigned v, int hi);
    if (v == 0) return 1;
    return (v > hi) ? hi : int'(v);
  endfunction

  function automatic int eff_rows();
    return clamp_cfg(cfg_rows, ROWS_MAX);
  endfunction

  function automatic int eff_width();
    return clamp_cfg(cfg_width, COLS_MAX);
  endfunction

  function automatic int eff_segs();
    return clamp_cfg(cfg_segs, SEGS_MAX);
  endfunction

  function automatic out_item_t predict_result(in_item_t it);
    out_item_t res;
    int ridx;
    int seg;
    int unsigned col;
    int rows;
    int width;
    int segs;
    res = '0;
    ridx = it.row_index;
    seg = it.segment_id;
    col = it.column;
    rows = eff_rows();
    width = eff_width();
    segs = eff_segs();
    res.status = ST_OK;
    case (it.mode)
      MODE_LOAD: begin
        if (ridx < 0 || ridx >= rows || col >= width) begin
          res.status = ST_IDX_RANGE;
          err_sticky = 1'b1;
        end else begin
          src_mem[ridx*COLS_MAX + col] = it.value;
        end
      end
      MODE_START: begin
        foreach (sum_mem[i]) sum_mem[i] = '0;
        err_sticky = 1'b0;
        have_seg = 1'b0;
        last_seg = 0;
      end
      MODE_PAIR: begin
        if (have_seg && seg < last_seg) res.status = ST_UNSORTED;
        else if (seg < 0 || seg >= segs) res.status = ST_SEG_RANGE;
        else if (ridx < 0 || ridx >= rows) res.status = ST_IDX_RANGE;
        if (res.status != ST_OK) begin
          err_sticky = 1'b1;
        end else begin
          for (int j = 0; j < width; j++)
            sum_mem[seg*COLS_MAX + j] = sum_mem[seg*COLS_MAX + j] + src_mem[ridx*COLS_MAX + j];
          last_seg = seg;
          have_seg = 1'b1;
        end
      end
      default: begin
        if (seg < 0 || seg >= segs) res.status = ST_SEG_RANGE;
        else if (col >= width) res.status = ST_IDX_RANGE;
        else res.read_data = sum_mem[seg*COLS_MAX + col];
      end
    endcase
    res.error_seen = err_sticky;
    return res;
  endfunction

  function automatic int draw_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic void queue_item(mode_t m, int r, int s, int c, logic [WORD_W-1:0] v);
    in_item_t it;
    it.mode = m;
    it.row_index = r;
    it.segment_id = s;
    it.column = c[3:0];
    it.value = v;
    if (m == MODE_LOAD && r >= 0 && r < eff_rows() && int'(it.column) < eff_width())
      loaded[r*COLS_MAX + it.column] = 1'b1;
    pending_items.push_back(it);
    items_queued++;
    phase_items++;
  endfunction

  function automatic logic [WORD_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return 32'hffff_ffff;
      3: return '0;
      default: return $urandom;
    endcase
  endfunction

  function automatic int pick_index(int limit);
    case ($urandom_range(0, 6))
      0: return -1;
      1: return limit;
      2: return limit - 1;
      3: return int'(32'h8000_0000);
      4: return 32'h7fff_ffff;
      5: return $urandom_range(0, limit - 1);
      default: return $urandom;
    endcase
  endfunction

  function automatic bit row_ready(int r);
    for (int c = 0; c < eff_width(); c++)
      if (!loaded[r*COLS_MAX + c]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic void fill_row(int r);
    for (int c = 0; c < eff_width(); c++)
      if (!loaded[r*COLS_MAX + c]) queue_item(MODE_LOAD, r, $urandom, c, pick_value());
  endfunction

  // pairs only ever gather rows whose columns in use were all loaded
  function automatic int ready_row();
    int r;
    repeat (8) begin
      r = $urandom_range(0, eff_rows() - 1);
      if (row_ready(r)) return r;
    end
    for (r = 0; r < eff_rows(); r++)
      if (row_ready(r)) return r;
    fill_row(0);
    return 0;
  endfunction

  function automatic int queue_noise(int seg_floor);
    mode_t m;
    int r;
    int s;
    m = mode_t'($urandom_range(0, 3));
    r = pick_index(eff_rows());
    s = pick_index(eff_segs());
    if (m == MODE_PAIR && r >= 0 && r < eff_rows() && !row_ready(r)) r = ready_row();
    queue_item(m, r, s, $urandom_range(0, 15), $urandom);
    if (m == MODE_START) return 0;
    if (m == MODE_PAIR && s >= seg_floor && s < eff_segs()) return s;
    return seg_floor;
  endfunction

  function automatic void queue_run(int unsigned len);
    int seg_floor;
    int kind;
    int s;
    seg_floor = 0;
    queue_item(MODE_START, $urandom, $urandom, $urandom_range(0, 15), $urandom);
    repeat (len) begin
      kind = $urandom_range(0, 99);
      if (kind < 12) begin
        seg_floor = queue_noise(seg_floor);
      end else if (kind < 35) begin
        queue_item(MODE_LOAD, $urandom_range(0, eff_rows() - 1), $urandom,
                   $urandom_range(0, eff_width() - 1), pick_value());
      end else if (kind < 75) begin
        s = seg_floor + $urandom_range(0, 2);
        if (s > eff_segs() - 1) s = eff_segs() - 1;
        queue_item(MODE_PAIR, ready_row(), s, $urandom_range(0, 15), pick_value());
        seg_floor = s;
      end else begin
        s = $urandom_range(0, 1) ? $urandom_range(0, seg_floor) : $urandom_range(0, eff_segs() - 1);
        queue_item(MODE_READ, $urandom, s, $urandom_range(0, eff_width() - 1), $urandom);
      end
    end
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned data);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wr_data <= data[CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      CFG_ROW_COUNT: cfg_rows = data[ROW_COUNT_W-1:0];
      CFG_ROW_WIDTH: cfg_width = data[ROW_WIDTH_W-1:0];
      CFG_NUM_SEGMENTS: cfg_segs = data[NUM_SEGMENTS_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_config(int unsigned rows, int unsigned width, int unsigned segs);
    write_reg(CFG_ROW_COUNT, rows);
    write_reg(CFG_ROW_WIDTH, width);
    write_reg(CFG_NUM_SEGMENTS, segs);
  endtask

  task automatic wait_idle();
    do @(posedge clk); while (results_seen < items_queued);
    repeat (8) @(posedge clk);
  endtask

  // input driver: one transfer per accepted item, random gaps afterwards
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid && !in_stall) begin
        predicted_results.push_back(predict_result(in_data));
        gap_left = draw_gap();
      end
      if (!(in_valid && in_stall)) begin
        if (gap_left > 0) begin
          in_valid <= 1'b0;
          gap_left--;
        end else if (pending_items.size() != 0) begin
          in_valid <= 1'b1;
          in_data <= pending_items.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result back-pressure, with one long hold to fill the block up
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (!hold_done && results_seen >= HOLD_AT) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      stall_left = draw_gap();
      out_stall <= (stall_left > 0);
      if (stall_left > 0) stall_left--;
    end
  end

  always @(posedge clk) begin
    quiet_cnt++;
    if (quiet_cnt % 256 == 0) quiet <= ($urandom_range(0, 3) == 0);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      results_seen <= results_seen + 1;
      if (predicted_results.size() == 0) begin
        $error("result transfer with nothing predicted");
        fail_count++;
      end else begin
        want = predicted_results.pop_front();
        if (out_data.status != want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_data.status);
          fail_count++;
        end
        if (out_data.read_data != want.read_data) begin
          $error("read_data: expected %0d, got %0d", want.read_data, out_data.read_data);
          fail_count++;
        end
        if (out_data.error_seen != want.error_seen) begin
          $error("error_seen: expected %0d, got %0d", want.error_seen, out_data.error_seen);
          fail_count++;
        end
      end
    end
  end

  initial begin
    #15_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    foreach (src_mem[i]) src_mem[i] = '0;
    foreach (sum_mem[i]) sum_mem[i] = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);
    while (in_stall) @(posedge clk);

    set_config(256, 4, 256);
    queue_item(MODE_START, 0, 0, 0, 0);
    queue_item(MODE_LOAD, 0, 0, 0, 32'h7fff_ffff);
    queue_item(MODE_LOAD, 0, 0, 1, 32'h8000_0000);
    queue_item(MODE_LOAD, 0, 0, 2, 32'hffff_ffff);
    queue_item(MODE_LOAD, 0, 0, 3, 32'h1);
    queue_item(MODE_LOAD, 255, 0, 0, 32'h7fff_ffff);
    queue_item(MODE_LOAD, 255, 0, 1, 32'h7fff_ffff);
    queue_item(MODE_LOAD, 255, 0, 2, 32'h8000_0000);
    queue_item(MODE_LOAD, 255, 0, 3, 32'h0);
    queue_item(MODE_PAIR, 0, 0, 0, 0);
    queue_item(MODE_PAIR, 255, 0, 0, 0);
    queue_item(MODE_PAIR, 0, 255, 0, 0);
    queue_item(MODE_PAIR, 0, 3, 0, 0);
    queue_item(MODE_PAIR, 0, 32'h7fff_ffff, 0, 0);
    queue_item(MODE_PAIR, 256, 255, 0, 0);
    queue_item(MODE_PAIR, int'(32'h8000_0000), 255, 0, 0);
    queue_item(MODE_READ, 0, 0, 0, 0);
    queue_item(MODE_READ, 0, 255, 3, 0);
    queue_item(MODE_READ, 0, -1, 0, 0);
    queue_item(MODE_READ, 0, 0, 4, 0);
    queue_item(MODE_READ, 0, int'(32'h8000_0000), 15, 0);
    queue_item(MODE_LOAD, 256, 0, 0, 32'h5);
    queue_item(MODE_LOAD, 0, 0, 15, 32'h5);
    queue_item(MODE_LOAD, -1, 0, 0, 32'h5);
    queue_item(MODE_START, -1, -1, 15, 32'hffff_ffff);
    queue_item(MODE_PAIR, 0, -1, 0, 0);
    queue_item(MODE_READ, 0, 0, 0, 0);
    wait_idle();

    for (int p = 0; p < 7; p++) begin
      case (p)
        0: set_config(256, 16, 256);
        1: set_config(1, 1, 1);
        2: set_config(0, 0, 0);
        3: set_config(511, 31, 511);
        4: set_config(37, 7, 20);
        5: set_config(200, 16, 5);
        default: set_config($urandom_range(1, 300), $urandom_range(1, 20), $urandom_range(1, 300));
      endcase
      phase_items = 0;
      fill_row(0);
      fill_row(eff_rows() - 1);
      queue_run($urandom_range(10, 30));
      // in the first phase, let every result of its first run come back before offering more
      if (p == 0) wait_idle();
      while (phase_items < 65) queue_run($urandom_range(10, 30));
      wait_idle();
    end

    repeat (20) @(posedge clk);
    if (fail_count == 0 && predicted_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
